// ===== rtl/cde_pkg.sv =====
// Shared types, constants and text tables for the character display expander.
package cde_pkg;

  localparam int COL_W     = 16;  // column field width
  localparam int CODE_W    = 8;   // character code width
  localparam int CFG_W     = 5;   // tab_width register width
  localparam int TXT_MAX   = 5;   // longest fixed text
  localparam int TXT_LEN_W = 3;
  localparam int DIV_BITS  = 4;   // column bits consumed per divider cycle
  localparam int DIV_STEPS = COL_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_W-1:0]  TAB_W_RESET = CFG_W'(8);
  localparam logic [CODE_W-1:0] CODE_TAB    = 8'd9;
  localparam logic [CODE_W-1:0] CODE_DEL    = 8'd127;
  localparam logic [CODE_W-1:0] CODE_SPACE  = 8'd32;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef logic [TXT_MAX-1:0][7:0] txt_chars_t;

  typedef struct packed {
    txt_chars_t           chars;  // chars[0] goes out first
    logic [TXT_LEN_W-1:0] len;
  } txt_t;

  // One queued request for the back end; tabs carry their count alongside.
  typedef struct packed {
    logic is_tab;
    txt_t txt;
  } desc_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } fr_state_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) r = 8'h30 + {4'h0, d};
    else           r = 8'h61 + {4'h0, d} - 8'd10;
    return r;
  endfunction

  function automatic txt_t mk_caret(input logic [7:0] c);
    txt_t t;
    t = '0;
    t.chars[0] = CH_CARET;
    t.chars[1] = c;
    t.len      = TXT_LEN_W'(2);
    return t;
  endfunction

  function automatic txt_t mk_angle2(input logic [7:0] a, input logic [7:0] b);
    txt_t t;
    t = '0;
    t.chars[0] = CH_LT;
    t.chars[1] = a;
    t.chars[2] = b;
    t.chars[3] = CH_GT;
    t.len      = TXT_LEN_W'(4);
    return t;
  endfunction

  function automatic txt_t mk_angle3(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
    txt_t t;
    t = '0;
    t.chars[0] = CH_LT;
    t.chars[1] = a;
    t.chars[2] = b;
    t.chars[3] = c;
    t.chars[4] = CH_GT;
    t.len      = TXT_LEN_W'(5);
    return t;
  endfunction

  // Names for codes 0..31.
  function automatic txt_t ctl_text(input logic [4:0] c);
    txt_t t;
    case (c)
      5'd0:    t = mk_angle3("N", "U", "L");
      5'd8:    t = mk_angle2("B", "S");
      5'd9:    t = mk_angle2("H", "T");
      5'd10:   t = mk_angle2("L", "F");
      5'd11:   t = mk_angle2("V", "T");
      5'd12:   t = mk_angle2("F", "F");
      5'd13:   t = mk_angle2("C", "R");
      5'd27:   t = mk_angle3("E", "S", "C");
      default: t = mk_caret(8'h40 + {3'b000, c});  // ^A .. ^_
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/char_display_expander_unit.sv =====
// Top level of the character display expander: config register, front, queue, back.
// Path: accepted request -> queue -> back end's current register -> registered output;
//   a tab first runs the remainder loop (four column bits each step) and the push state.
// Throughput: one character per cycle out while the queue holds requests; non-tab requests
//   go in every cycle while the two-entry queue has room, a tab holds busy through its loop.
// Reset: synchronous on rst_n low, clears control state only, tab_width = 8. No receiver stall.
module char_display_expander_unit import cde_pkg::*; #(
  parameter int MAX_TAB = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // request side
  input  logic              start,
  output logic              busy,
  input  logic [CODE_W-1:0] in_char_code,
  input  logic [COL_W-1:0]  in_column,
  // result side
  output logic              out_valid,
  output logic [7:0]        out_char,
  output logic              out_last
);

  localparam int LW = $clog2(MAX_TAB + 1);
  localparam int QW = $bits(desc_t) + LW;

  logic [CFG_W-1:0] tab_width_r;

  // front -> queue
  logic          push;
  desc_t         push_desc;
  logic [LW-1:0] push_cnt;
  logic          q_full;

  // queue -> back
  logic          pop;
  logic          q_not_empty;
  logic [QW-1:0] q_data;
  desc_t         q_desc;
  logic [LW-1:0] q_cnt;

  // Only register; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r <= TAB_W_RESET;
    end else if (cfg_we) begin
      tab_width_r <= cfg_wdata;
    end
  end

  // Front: classifies each request, computes tab space counts.
  cde_front #(.MAX_TAB(MAX_TAB), .LW(LW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .char_code (in_char_code),
    .column    (in_column),
    .tab_width (tab_width_r),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_desc (push_desc),
    .push_cnt  (push_cnt)
  );

  // Decouples front and back so a long tab run does not block classification.
  cde_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_desc, push_cnt}),
    .pop       (pop),
    .pop_data  (q_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign q_desc = q_data[QW-1:LW];
  assign q_cnt  = q_data[LW-1:0];

  // Back: character sequencer with registered output.
  cde_back #(.MAX_TAB(MAX_TAB), .LW(LW)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_desc      (q_desc),
    .q_cnt       (q_cnt),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_char    (out_char),
    .out_last    (out_last)
  );

  // Front never pushes into a full queue unless the back frees a slot that cycle.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> (!q_full || pop))
    else $error("push into full request queue");

  // A tab request always carries between 1 and MAX_TAB spaces.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_desc.is_tab) |-> (push_cnt != '0) && (int'(push_cnt) <= MAX_TAB))
    else $error("tab space count out of range");

  // An accepted tab holds the front off on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_char_code == CODE_TAB)) |=> busy)
    else $error("front took a request during tab remainder");

  // A strobe is only raised after a request was queued.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop, 2) || $past(out_valid, 1))
    else $error("result strobe without a queued request");

endmodule

// ===== rtl/cde_front.sv =====
// Front end: accepts requests, classifies them, runs the tab remainder loop.
module cde_front import cde_pkg::*; #(
  parameter int MAX_TAB = 16,
  parameter int LW      = $clog2(MAX_TAB + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CODE_W-1:0] char_code,
  input  logic [COL_W-1:0]  column,
  input  logic [CFG_W-1:0]  tab_width,
  input  logic              q_full,
  output logic              busy,
  output logic              push,
  output desc_t             push_desc,
  output logic [LW-1:0]     push_cnt
);

  fr_state_t          state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [LW-1:0]      w_r, w_nxt;
  logic [LW-1:0]      rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [LW-1:0]      w_clamp;
  logic               accept;
  txt_t               txt;

  always_comb begin
    if (tab_width == '0)                  w_clamp = LW'(1);
    else if (int'(tab_width) > MAX_TAB)   w_clamp = LW'(MAX_TAB);
    else                                  w_clamp = LW'(tab_width);
  end

  // Fixed text for everything but tabs.
  always_comb begin
    txt = '0;
    if (char_code[7]) begin
      txt.chars[0] = CH_LT;
      txt.chars[1] = CH_X;
      txt.chars[2] = hex_digit(char_code[7:4]);
      txt.chars[3] = hex_digit(char_code[3:0]);
      txt.chars[4] = CH_GT;
      txt.len      = TXT_LEN_W'(5);
    end else if (char_code == CODE_DEL) begin
      txt = mk_angle3("D", "E", "L");
    end else if (char_code < CODE_SPACE) begin
      txt = ctl_text(char_code[4:0]);
    end else begin
      txt.chars[0] = char_code;
      txt.len      = TXT_LEN_W'(1);
    end
  end

  assign busy   = (state_r != FR_IDLE) || q_full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    col_r  <= col_nxt;
    w_r    <= w_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  always_comb begin
    logic [LW:0] r;
    state_nxt = state_r;
    col_nxt   = col_r;
    w_nxt     = w_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    push      = 1'b0;
    push_desc = '0;
    push_cnt  = w_r - rem_r;
    r         = '0;
    case (state_r)
      FR_IDLE: begin
        if (accept) begin
          if (char_code == CODE_TAB) begin
            col_nxt   = column;
            w_nxt     = w_clamp;
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = FR_DIV;
          end else begin
            push          = 1'b1;
            push_desc.txt = txt;
          end
        end
      end
      FR_DIV: begin
        // restoring remainder, DIV_BITS column bits per cycle, MSB first
        r = {1'b0, rem_r};
        for (int i = 0; i < DIV_BITS; i++) begin
          r = {r[LW-1:0], col_r[COL_W-1-i]};
          if (r >= {1'b0, w_r}) r = r - {1'b0, w_r};
        end
        rem_nxt  = r[LW-1:0];
        col_nxt  = col_r << DIV_BITS;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = FR_PUSH;
      end
      FR_PUSH: begin
        if (!q_full) begin
          push             = 1'b1;
          push_desc.is_tab = 1'b1;
          state_nxt        = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

endmodule

// ===== rtl/cde_queue.sv =====
// Two-entry request queue between front and back end.
module cde_queue import cde_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         not_empty
);

  logic [W-1:0]    entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_CW-1:0] cnt_r;

  assign full      = (cnt_r == Q_CW'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = entry_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + Q_AW'(1);
      if (pop)  rd_r <= rd_r + Q_AW'(1);
      if (push && !pop)      cnt_r <= cnt_r + Q_CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - Q_CW'(1);
    end
    if (push) entry_r[wr_r] <= push_data;
  end

endmodule

// ===== rtl/cde_back.sv =====
// Back end: walks one queued request and emits one character per cycle.
module cde_back import cde_pkg::*; #(
  parameter int MAX_TAB = 16,
  parameter int LW      = $clog2(MAX_TAB + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  desc_t         q_desc,
  input  logic [LW-1:0] q_cnt,
  output logic          pop,
  output logic          out_valid,
  output logic [7:0]    out_char,
  output logic          out_last
);

  logic          cur_vld_r;
  desc_t         cur_desc_r;
  logic [LW-1:0] cur_cnt_r;
  logic [LW-1:0] idx_r;
  logic [LW-1:0] len;
  logic          at_end;
  logic          out_valid_r;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_last_r;

  assign len    = cur_desc_r.is_tab ? cur_cnt_r : LW'(cur_desc_r.txt.len);
  assign at_end = (idx_r == len - LW'(1));
  assign pop    = q_not_empty && (!cur_vld_r || at_end);

  always_comb begin
    if (cur_desc_r.is_tab) out_char_nxt = CH_SPACE;
    else                   out_char_nxt = cur_desc_r.txt.chars[idx_r[TXT_LEN_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cur_vld_r;
      if (pop)                       cur_vld_r <= 1'b1;
      else if (cur_vld_r && at_end)  cur_vld_r <= 1'b0;
    end
    if (pop) begin
      cur_desc_r <= q_desc;
      cur_cnt_r  <= q_cnt;
      idx_r      <= '0;
    end else if (cur_vld_r && !at_end) begin
      idx_r <= idx_r + LW'(1);
    end
    out_char_r <= out_char_nxt;
    out_last_r <= at_end;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// ===== bench/char_display_expander_unit_test.sv =====
// Self-checking bench for the character display expander: directed table, then random requests.
module char_display_expander_unit_test;
  import cde_pkg::*;

  // Tab stop clamp used by the DUT instance and by the predictor below.
  localparam int TAB_LIMIT = 16;

  // Random part: one tab_width setting per phase, extremes first, then 8, 3 and 15, then a random one.
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 51;
  localparam int GAP_PCT     = 7;
  // Cycles allowed after the last character before a config write or the verdict.
  // The slowest path is the tab, which runs the remainder loop before it is queued.
  localparam int SETTLE_CYCLES = 12;

  // One displayed character as it leaves the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } disp_char_t;

  // Directed stimulus row. A non-zero text is the expected display, typed in,
  // right-aligned in the usual string-literal way (leading zero bytes unused).
  // A zero text means the row is checked against the predictor.
  typedef struct packed {
    logic              set_width;  // drain, then write tab_width first
    logic [CFG_W-1:0]  width;
    logic [CODE_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [127:0]      text;
  } stim_row_t;

  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // tab_width is still at its reset value of 8 here
    '{1'b0, 5'd0,  8'h00,    16'd0,      "<NUL>"},
    '{1'b0, 5'd0,  8'h01,    16'd3,      "^A"},
    '{1'b0, 5'd0,  8'h08,    16'd9,      "<BS>"},
    '{1'b0, 5'd0,  CODE_TAB, 16'd0,      "        "},
    '{1'b0, 5'd0,  CODE_TAB, 16'd7,      " "},
    '{1'b0, 5'd0,  CODE_TAB, 16'hFFFF,   " "},
    '{1'b0, 5'd0,  CODE_TAB, 16'd12,     "    "},
    '{1'b0, 5'd0,  8'h0D,    16'd1,      "<CR>"},
    '{1'b0, 5'd0,  8'h1B,    16'd2,      "<ESC>"},
    '{1'b0, 5'd0,  8'h1C,    16'd4,      "^\\"},
    '{1'b0, 5'd0,  8'h1F,    16'd5,      "^_"},
    '{1'b0, 5'd0,  8'h20,    16'hFFFF,   " "},
    '{1'b0, 5'd0,  8'h41,    16'h8000,   "A"},
    '{1'b0, 5'd0,  8'h7E,    16'h00FF,   "~"},
    '{1'b0, 5'd0,  CODE_DEL, 16'hAAAA,   "<DEL>"},
    '{1'b0, 5'd0,  8'h80,    16'h0100,   "<x80>"},
    '{1'b0, 5'd0,  8'hAB,    16'h5555,   "<xab>"},
    '{1'b0, 5'd0,  8'hFF,    16'hFFFF,   "<xff>"},
    // width 0 acts as 1: always exactly one space
    '{1'b1, 5'd0,  CODE_TAB, 16'd1234,   " "},
    // width 31 is clamped to the tab limit
    '{1'b1, 5'd31, CODE_TAB, 16'd0,      128'h0},
    '{1'b0, 5'd0,  CODE_TAB, 16'd15,     128'h0},
    '{1'b1, 5'd16, CODE_TAB, 16'hFFFF,   128'h0},
    '{1'b1, 5'd5,  CODE_TAB, 16'd3,      128'h0},
    '{1'b0, 5'd0,  8'h0A,    16'd0,      "<LF>"}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [CODE_W-1:0] in_char_code = '0;
  logic [COL_W-1:0]  in_column = '0;
  logic              out_valid;
  logic [7:0]        out_char;
  logic              out_last;

  // Bench copy of the tab_width register, updated at the write edge.
  logic [CFG_W-1:0] tab_width_shadow;
  // Display characters still owed by the DUT, oldest first.
  disp_char_t       owed_chars[$];
  int unsigned      err_count = 0;
  // Set during one phase to get a long run of back-to-back requests.
  bit               steady_flow = 1'b0;

  always #5 clk = ~clk;

  char_display_expander_unit #(.MAX_TAB(TAB_LIMIT)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_char_code (in_char_code),
    .in_column    (in_column),
    .out_valid    (out_valid),
    .out_char     (out_char),
    .out_last     (out_last)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Queue a display text; bytes are taken from the highest non-zero one down,
  // so the first character of a string literal goes out first.
  function automatic void owe_text(input logic [127:0] text);
    int hi;
    hi = -1;
    for (int i = 0; i < 16; i++) if (text[i*8 +: 8] != 8'h00) hi = i;
    for (int i = hi; i >= 0; i--) owed_chars.push_back('{text[i*8 +: 8], i == 0});
  endfunction

  function automatic logic [7:0] nibble_hex(input logic [3:0] nib);
    logic [7:0] c;
    c = (nib < 4'd10) ? ("0" + 8'(nib)) : ("a" + 8'(nib) - 8'd10);
    return c;
  endfunction

  // Caret or angle name of a control code below 32.
  function automatic logic [39:0] control_name(input logic [4:0] c);
    logic [39:0] t;
    case (c)
      5'd0:    t = "<NUL>";
      5'd8:    t = "<BS>";
      5'd9:    t = "<HT>";
      5'd10:   t = "<LF>";
      5'd11:   t = "<VT>";
      5'd12:   t = "<FF>";
      5'd13:   t = "<CR>";
      5'd27:   t = "<ESC>";
      default: t = {24'h0, CH_CARET, 8'(8'h40 + 8'(c))};
    endcase
    return t;
  endfunction

  // Work out the characters one request displays and queue them.
  function automatic void predict_display(input logic [CODE_W-1:0] code,
                                          input logic [COL_W-1:0] col);
    logic [127:0] text;
    int unsigned  stop;
    int unsigned  n_spaces;
    text = '0;
    if (code[7]) begin
      text = {"<x", nibble_hex(code[7:4]), nibble_hex(code[3:0]), ">"};
    end else if (code == CODE_DEL) begin
      text = "<DEL>";
    end else if (code == CODE_TAB) begin
      // width in use is the register clamped to 1..TAB_LIMIT
      stop = tab_width_shadow;
      if (stop < 1) stop = 1;
      if (stop > TAB_LIMIT) stop = TAB_LIMIT;
      n_spaces = stop - (col % stop);
      for (int i = 0; i < n_spaces; i++) text[i*8 +: 8] = CH_SPACE;
    end else if (code < CODE_SPACE) begin
      text = {88'h0, control_name(code[4:0])};
    end else begin
      text = {120'h0, code};
    end
    owe_text(text);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: out_valid can't be held off, so every strobe is a result.
  // Sampled at the edge, before the DUT's flops update.
  // ---------------------------------------------------------------------------

  function automatic void log_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin : check_display
    disp_char_t want;
    if (rst_n && out_valid) begin
      if (owed_chars.size() == 0) begin
        log_error($sformatf("unexpected char 0x%02h last=%0b", out_char, out_last));
      end else begin
        want = owed_chars.pop_front();
        if (out_char !== want.ch || out_last !== want.last)
          log_error($sformatf("char 0x%02h last=%0b, expected 0x%02h last=%0b",
                              out_char, out_last, want.ch, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Present one request and hold it until accepted (start high, busy low at
  // an edge). start stays high on return so back-to-back requests need no
  // extra assignment; callers lower it when they stop sending.
  task automatic send_request(input logic [CODE_W-1:0] code,
                              input logic [COL_W-1:0] col,
                              input logic [127:0] typed_text);
    if (!steady_flow && $urandom_range(99) < GAP_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start        <= 1'b1;
    in_char_code <= code;
    in_column    <= col;
    do @(posedge clk); while (busy);
    if (typed_text != '0) owe_text(typed_text);
    else predict_display(code, col);
  endtask

  // Stop sending and wait until every owed character has come out, then let
  // the block settle. Only place tab_width is allowed to change.
  task automatic drain_requests();
    start <= 1'b0;
    while (owed_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tab_width(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tab_width_shadow = value;
    cfg_we    <= 1'b0;
  endtask

  // Mix biased toward the interesting classes: tabs, controls, DEL, high bytes.
  function automatic logic [CODE_W-1:0] random_code();
    int unsigned  r;
    logic [7:0]   c;
    r = $urandom_range(99);
    if (r < 22)      c = CODE_TAB;
    else if (r < 42) c = 8'($urandom_range(0, 31));
    else if (r < 47) c = CODE_DEL;
    else if (r < 70) c = 8'($urandom_range(128, 255));
    else if (r < 90) c = 8'($urandom_range(32, 126));
    else             c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [COL_W-1:0] random_column();
    int unsigned  r;
    logic [15:0]  c;
    r = $urandom_range(99);
    if (r < 15)      c = 16'($urandom_range(0, 40));
    else if (r < 20) c = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    else             c = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [CFG_W-1:0] width;
    tab_width_shadow = TAB_W_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, every class of code, tab width clamps.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].set_width) begin
        drain_requests();
        write_tab_width(DIRECTED[i].width);
      end
      send_request(DIRECTED[i].code, DIRECTED[i].col, DIRECTED[i].text);
    end

    // Random phases; each starts from an idle block with a fresh tab_width.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       width = 5'd0;
        1:       width = 5'd1;
        2:       width = 5'd16;
        3:       width = 5'd31;
        4:       width = 5'd8;
        5:       width = 5'd3;
        6:       width = 5'd15;
        default: width = 5'($urandom_range(0, 31));
      endcase
      drain_requests();
      write_tab_width(width);
      // phase 4 runs with no gaps at all
      steady_flow = (p == 4);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_request(random_code(), random_column(), 128'h0);
    end
    steady_flow = 1'b0;

    drain_requests();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop: ends the run if it hangs.
  initial begin : watchdog
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
